// ===== rtl/integer_ir_alu_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef INTEGER_IR_ALU_UNIT_DEFINES_SVH
`define INTEGER_IR_ALU_UNIT_DEFINES_SVH

// Flag an expression that must never hold out of reset.
`define IAA_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("never condition hit");

// Flag a consequent that fails to follow its antecedent in the same cycle.
`define IAA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ===== rtl/iaa_pkg.sv =====
`timescale 1ns / 1ps
package iaa_pkg;

    localparam int unsigned DivSteps = 64;

    typedef enum logic [4:0] {
        CMD_IMM     = 5'd0,
        CMD_ADD32   = 5'd1,
        CMD_SUB32   = 5'd2,
        CMD_MUL32   = 5'd3,
        CMD_DIV32   = 5'd4,
        CMD_MOD32   = 5'd5,
        CMD_EQ32    = 5'd6,
        CMD_NE32    = 5'd7,
        CMD_LT32    = 5'd8,
        CMD_LE32    = 5'd9,
        CMD_AND32   = 5'd10,
        CMD_OR32    = 5'd11,
        CMD_XOR32   = 5'd12,
        CMD_SHL32   = 5'd13,
        CMD_ADD64   = 5'd14,
        CMD_SUB64   = 5'd15,
        CMD_MUL64   = 5'd16,
        CMD_DIV64   = 5'd17,
        CMD_MOD64   = 5'd18,
        CMD_SHL64   = 5'd19,
        CMD_SHR64   = 5'd20,
        CMD_NOT32   = 5'd21,
        CMD_SETNZ32 = 5'd22,
        CMD_NEG32   = 5'd23,
        CMD_SHR32   = 5'd24,
        CMD_SELECT  = 5'd25
    } cmd_t;

    // Word carried alongside the divide datapath.
    typedef struct packed {
        logic [63:0] res;
        logic        dz;
        logic        is_div;
        logic        is_mod;
        logic        is32;
        logic        neg_q;
        logic        neg_r;
    } side_t;

    typedef struct packed {
        logic        valid;
        side_t       side;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dsr;
    } cell_t;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== rtl/iaa_front.sv =====
`timescale 1ns / 1ps
module iaa_front
    import iaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [4:0]  command,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    output cell_t       cell_out
);

    logic        s1_valid_reg;
    logic        s1_mul64_reg;
    logic        s1_mul32_reg;
    side_t       s1_side_reg;
    logic [63:0] s1_dvd_reg;
    logic [63:0] s1_dsr_reg;
    logic [63:0] s1_pll_reg;
    logic [31:0] s1_plh_reg;
    logic [31:0] s1_phl_reg;

    logic        s2_valid_reg;
    cell_t       s2_cell_reg;

    side_t       side_next;
    side_t       s2_side_next;
    logic [63:0] a32;
    logic [63:0] b32;
    logic [63:0] src_a;
    logic [63:0] src_b;
    logic [31:0] lo32;
    logic [63:0] dvd_next;
    logic [63:0] dsr_next;
    logic        is_mul64;
    logic        is_mul32;

    always_comb
    begin
        a32       = sx32(operand_a[31:0]);
        b32       = sx32(operand_b[31:0]);
        side_next = '0;
        lo32      = '0;
        is_mul64  = 1'b0;
        is_mul32  = 1'b0;
        unique case (command) inside
            CMD_IMM:     side_next.res = operand_a;
            CMD_ADD32:
            begin
                lo32          = operand_a[31:0] + operand_b[31:0];
                side_next.res = sx32(lo32);
            end
            CMD_SUB32:
            begin
                lo32          = operand_a[31:0] - operand_b[31:0];
                side_next.res = sx32(lo32);
            end
            CMD_MUL32:   is_mul32 = 1'b1;
            CMD_MUL64:   is_mul64 = 1'b1;
            CMD_DIV32, CMD_MOD32:
            begin
                side_next.is_div = 1'b1;
                side_next.is32   = 1'b1;
                side_next.is_mod = (command == CMD_MOD32);
                side_next.dz     = (operand_b[31:0] == 32'd0);
            end
            CMD_DIV64, CMD_MOD64:
            begin
                side_next.is_div = 1'b1;
                side_next.is_mod = (command == CMD_MOD64);
                side_next.dz     = (operand_b == 64'd0);
            end
            CMD_EQ32:    side_next.res = {63'd0, a32 == b32};
            CMD_NE32:    side_next.res = {63'd0, a32 != b32};
            CMD_LT32:    side_next.res = {63'd0, $signed(a32) < $signed(b32)};
            CMD_LE32:    side_next.res = {63'd0, $signed(a32) <= $signed(b32)};
            CMD_AND32:   side_next.res = sx32(operand_a[31:0] & operand_b[31:0]);
            CMD_OR32:    side_next.res = sx32(operand_a[31:0] | operand_b[31:0]);
            CMD_XOR32:   side_next.res = sx32(operand_a[31:0] ^ operand_b[31:0]);
            CMD_SHL32:
            begin
                lo32          = operand_a[31:0] << operand_b[4:0];
                side_next.res = sx32(lo32);
            end
            CMD_ADD64:   side_next.res = operand_a + operand_b;
            CMD_SUB64:   side_next.res = operand_a - operand_b;
            CMD_SHL64:   side_next.res = operand_a << operand_b[5:0];
            CMD_SHR64:   side_next.res = $signed(operand_a) >>> operand_b[5:0];
            CMD_NOT32:   side_next.res = {63'd0, operand_a[31:0] == 32'd0};
            CMD_SETNZ32: side_next.res = {63'd0, operand_a[31:0] != 32'd0};
            CMD_NEG32:
            begin
                lo32          = 32'd0 - operand_a[31:0];
                side_next.res = sx32(lo32);
            end
            CMD_SHR32:
            begin
                lo32          = $signed(operand_a[31:0]) >>> operand_b[4:0];
                side_next.res = sx32(lo32);
            end
            CMD_SELECT:  side_next.res = (operand_a != 64'd0) ? operand_b : operand_c;
            default:     side_next.res = '0;
        endcase
        src_a           = side_next.is32 ? a32 : operand_a;
        src_b           = side_next.is32 ? b32 : operand_b;
        side_next.neg_r = src_a[63];
        side_next.neg_q = src_a[63] ^ src_b[63];
        dvd_next        = src_a[63] ? (64'd0 - src_a) : src_a;
        dsr_next        = src_b[63] ? (64'd0 - src_b) : src_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg  <= side_next;
        s1_mul64_reg <= is_mul64;
        s1_mul32_reg <= is_mul32;
        s1_dvd_reg   <= dvd_next;
        s1_dsr_reg   <= dsr_next;
        s1_pll_reg   <= {32'd0, operand_a[31:0]} * {32'd0, operand_b[31:0]};
        s1_plh_reg   <= operand_a[31:0] * operand_b[63:32];
        s1_phl_reg   <= operand_a[63:32] * operand_b[31:0];
    end

    // Fold the partial products in the second stage.
    always_comb
    begin
        s2_side_next = s1_side_reg;
        if (s1_mul64_reg)
            s2_side_next.res = s1_pll_reg + {s1_plh_reg + s1_phl_reg, 32'd0};
        else if (s1_mul32_reg)
            s2_side_next.res = sx32(s1_pll_reg[31:0]);
    end

    always_ff @(posedge clk)
    begin
        s2_cell_reg.side  <= s2_side_next;
        s2_cell_reg.rem   <= '0;
        s2_cell_reg.quo   <= s1_dvd_reg;
        s2_cell_reg.dsr   <= s1_dsr_reg;
        s2_cell_reg.valid <= 1'b0;
    end

    always_comb
    begin
        cell_out       = s2_cell_reg;
        cell_out.valid = s2_valid_reg;
    end

endmodule

// ===== rtl/iaa_div_cell.sv =====
`timescale 1ns / 1ps
module iaa_div_cell
    import iaa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t cell_in,
    output cell_t cell_out
);

    logic        valid_reg;
    cell_t       data_reg;
    logic [64:0] shifted;
    logic [64:0] trial;
    cell_t       data_next;

    // One restoring step: shift in a dividend bit, subtract when it fits.
    always_comb
    begin
        data_next = cell_in;
        shifted   = {cell_in.rem, cell_in.quo[63]};
        trial     = shifted - {1'b0, cell_in.dsr};
        if (!trial[64])
        begin
            data_next.rem = trial[63:0];
            data_next.quo = {cell_in.quo[62:0], 1'b1};
        end
        else
        begin
            data_next.rem = shifted[63:0];
            data_next.quo = {cell_in.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

// ===== rtl/integer_ir_alu_unit.sv =====
`timescale 1ns / 1ps
// Integer execution unit for 32/64-bit operations with signed divide. It
// takes a new operation word in every cycle (busy stays low) and returns
// each result in order, with done high for one cycle; the receiver cannot
// stall, so results are not held. The divider is a row of 64 restoring
// cells, one quotient bit per cell, which every operation passes through.
// Two front stages decode the word, form the divide magnitudes and the
// 32x32 partial products of the multiply and sum them, and one output
// stage fixes the quotient and remainder signs. A zero divisor gives 0
// with divide_by_zero set; MIN / -1 wraps.
module integer_ir_alu_unit
    import iaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  command,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    output logic        done,
    output logic [63:0] result_value,
    output logic        divide_by_zero
);

    cell_t       chain [DivSteps+1];
    logic        done_reg;
    logic [63:0] result_reg;
    logic        dz_reg;
    logic [63:0] quo_s;
    logic [63:0] rem_s;
    logic [63:0] val_sel;
    logic [63:0] result_next;
    side_t       tail;

    // The unit never stalls the issuer.
    assign busy = 1'b0;

    iaa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .cell_out  (chain[0])
    );

    // Divider row: each cell advances one quotient bit per cycle.
    for (genvar i = 0; i < DivSteps; i++)
    begin : g_cell
        iaa_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Apply signs, pick quotient or remainder, narrow for 32-bit ops.
    always_comb
    begin
        tail    = chain[DivSteps].side;
        quo_s   = tail.neg_q ? (64'd0 - chain[DivSteps].quo) : chain[DivSteps].quo;
        rem_s   = tail.neg_r ? (64'd0 - chain[DivSteps].rem) : chain[DivSteps].rem;
        val_sel = tail.is_mod ? rem_s : quo_s;
        if (!tail.is_div)
            result_next = tail.res;
        else if (tail.dz)
            result_next = '0;
        else if (tail.is32)
            result_next = sx32(val_sel[31:0]);
        else
            result_next = val_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[DivSteps].valid;
    end

    // Drop the flag on bubbles so it only shows with done.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        dz_reg     <= chain[DivSteps].valid & tail.is_div & tail.dz;
    end

    assign done           = done_reg;
    assign result_value   = result_reg;
    assign divide_by_zero = dz_reg;

endmodule

// ===== rtl/iaa_checker.sv =====
`timescale 1ns / 1ps
`include "integer_ir_alu_unit_defines.svh"
module iaa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [63:0] result_value,
    input logic        divide_by_zero
);

    `IAA_ASSERT_NEVER(a_never_busy, busy)
    `IAA_ASSERT_IMPLY(a_dz_only_on_done, divide_by_zero, done)
    `IAA_ASSERT_IMPLY(a_dz_zero_result, done && divide_by_zero, result_value == 64'd0)

endmodule

bind integer_ir_alu_unit iaa_checker u_iaa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .done           (done),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero)
);

// ===== tb/integer_ir_alu_unit_tb.sv =====
`timescale 1ns / 1ps
module integer_ir_alu_unit_tb
    import iaa_pkg::*;
();

    localparam int LATENCY    = 67;
    localparam int WATCHDOG   = 4000;
    localparam int RANDOM_OPS = 1900;

    typedef struct packed {
        logic [4:0]  command;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [63:0] operand_c;
    } alu_word_t;

    typedef struct packed {
        logic [63:0] value;
        logic        dz;
    } alu_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] operand_c;
    logic        done;
    logic [63:0] result_value;
    logic        divide_by_zero;

    alu_word_t   pending_words[$];
    alu_result_t expected_results[$];
    int          error_count;
    int          idle_cycles;
    int          gap_left;
    int          words_sent;
    int          results_seen;

    integer_ir_alu_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .operand_c      (operand_c),
        .done           (done),
        .result_value   (result_value),
        .divide_by_zero (divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [63:0] ext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Signed truncating divide on 64-bit patterns; the divisor is nonzero.
    function automatic void signed_divide(input logic [63:0] a, input logic [63:0] b,
                                          output logic [63:0] q, output logic [63:0] r);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] uq;
        logic [63:0] ur;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        uq = ma / mb;
        ur = ma % mb;
        q  = (a[63] != b[63]) ? -uq : uq;
        r  = a[63] ? -ur : ur;
    endfunction

    function automatic alu_result_t compute_alu(input alu_word_t w);
        alu_result_t res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] a32;
        logic [63:0] b32;
        logic [63:0] q;
        logic [63:0] r;
        a   = w.operand_a;
        b   = w.operand_b;
        a32 = ext32(a);
        b32 = ext32(b);
        res = '0;
        case (w.command) inside
            CMD_IMM:     res.value = a;
            CMD_ADD32:   res.value = ext32(a + b);
            CMD_SUB32:   res.value = ext32(a - b);
            CMD_MUL32:   res.value = ext32({32'd0, a[31:0]} * {32'd0, b[31:0]});
            CMD_DIV32, CMD_MOD32:
            begin
                if (b32 == 64'd0)
                begin
                    res.dz = 1'b1;
                end
                else
                begin
                    signed_divide(a32, b32, q, r);
                    res.value = ext32((w.command == CMD_DIV32) ? q : r);
                end
            end
            CMD_EQ32:    res.value = {63'd0, a32 == b32};
            CMD_NE32:    res.value = {63'd0, a32 != b32};
            CMD_LT32:    res.value = {63'd0, $signed(a32) < $signed(b32)};
            CMD_LE32:    res.value = {63'd0, $signed(a32) <= $signed(b32)};
            CMD_AND32:   res.value = ext32(a & b);
            CMD_OR32:    res.value = ext32(a | b);
            CMD_XOR32:   res.value = ext32(a ^ b);
            CMD_SHL32:   res.value = ext32({32'd0, a[31:0]} << b[4:0]);
            CMD_ADD64:   res.value = a + b;
            CMD_SUB64:   res.value = a - b;
            CMD_MUL64:   res.value = a * b;
            CMD_DIV64, CMD_MOD64:
            begin
                if (b == 64'd0)
                begin
                    res.dz = 1'b1;
                end
                else
                begin
                    signed_divide(a, b, q, r);
                    res.value = (w.command == CMD_DIV64) ? q : r;
                end
            end
            CMD_SHL64:   res.value = a << b[5:0];
            CMD_SHR64:   res.value = $signed(a) >>> b[5:0];
            CMD_NOT32:   res.value = {63'd0, a[31:0] == 32'd0};
            CMD_SETNZ32: res.value = {63'd0, a[31:0] != 32'd0};
            CMD_NEG32:   res.value = ext32(-a);
            CMD_SHR32:   res.value = ext32($signed(a32) >>> b[4:0]);
            CMD_SELECT:  res.value = (a != 64'd0) ? b : w.operand_c;
            default:     res.value = 64'd0;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Bias operands toward corners, small values and 32-bit boundaries.
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = 64'h8000_0000_0000_0000;
            2: v = 64'hFFFF_FFFF_FFFF_FFFF;
            3: v = 64'h7FFF_FFFF_FFFF_FFFF;
            4: v = ext32({32'd0, ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)});
            5: v = {$urandom(), 32'd0};
            6: v = $signed(64'($urandom_range(0, 40))) - 64'sd20;
            7: v = ext32({32'd0, $urandom()});
            default: v = rand64();
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic [4:0] cmd, input logic [63:0] a,
                              input logic [63:0] b, input logic [63:0] c);
        alu_word_t w;
        w.command   = cmd;
        w.operand_a = a;
        w.operand_b = b;
        w.operand_c = c;
        pending_words = {pending_words, w};
    endtask

    initial
    begin
        logic [63:0] min64;
        logic [63:0] min32;
        min64 = 64'h8000_0000_0000_0000;
        min32 = 64'hFFFF_FFFF_8000_0000;
        // Directed: corners, zero divisors, MIN / -1 wrap, shift masking.
        queue_word(CMD_IMM, min64, 64'd0, 64'd0);
        queue_word(CMD_IMM, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1);
        queue_word(CMD_DIV32, 64'd7, 64'hFFFF_FFFF_0000_0000, 64'd0);
        queue_word(CMD_MOD32, 64'd7, 64'd0, 64'd0);
        queue_word(CMD_DIV64, 64'd7, 64'd0, 64'd0);
        queue_word(CMD_MOD64, '1, 64'd0, 64'd0);
        queue_word(CMD_DIV64, min64, '1, 64'd0);
        queue_word(CMD_MOD64, min64, '1, 64'd0);
        queue_word(CMD_DIV32, min32, '1, 64'd0);
        queue_word(CMD_MOD32, min32, '1, 64'd0);
        queue_word(CMD_DIV64, -64'sd7, 64'd2, 64'd0);
        queue_word(CMD_MOD64, -64'sd7, 64'd2, 64'd0);
        queue_word(CMD_SHL32, 64'd1, 64'd63, 64'd0);
        queue_word(CMD_SHL64, 64'd1, 64'd127, 64'd0);
        queue_word(CMD_SHR64, min64, 64'd63, 64'd0);
        queue_word(CMD_SHR32, min32, 64'd31, 64'd0);
        queue_word(CMD_SELECT, min64, 64'd5, 64'd9);
        queue_word(CMD_SELECT, 64'd0, 64'd5, 64'd9);
        queue_word(CMD_NOT32, 64'hFFFF_FFFF_0000_0000, 64'd0, 64'd0);
        queue_word(CMD_SETNZ32, 64'hFFFF_FFFF_0000_0000, 64'd0, 64'd0);
        queue_word(CMD_NEG32, min32, 64'd0, 64'd0);
        queue_word(CMD_LE32, 64'd5, 64'hFFFF_FFFF_0000_0005, 64'd0);
        queue_word(CMD_MUL64, '1, '1, 64'd0);
        queue_word(5'd26, '1, '1, '1);
        queue_word(5'd31, '1, '1, '1);
        // Random: mostly defined opcodes, a few undefined ones.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            queue_word(($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                                    : 5'($urandom_range(0, 25)),
                       pick_operand(), pick_operand(), pick_operand());
        end
    end

    // Driver: hold start while a word is offered, advance on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            command    <= '0;
            operand_a  <= '0;
            operand_b  <= '0;
            operand_c  <= '0;
            gap_left   <= 0;
            words_sent <= 0;
        end
        else
        begin
            logic accepted;
            logic offer;
            accepted = start && !busy;
            if (accepted)
            begin
                expected_results = {expected_results,
                                    compute_alu({command, operand_a,
                                                 operand_b, operand_c})};
                words_sent <= words_sent + 1;
            end
            offer = 1'b0;
            if (!start || accepted)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    offer = 1'b1;
                end
                if (offer)
                begin
                    alu_word_t w;
                    w = pending_words.pop_front();
                    command   <= w.command;
                    operand_a <= w.operand_a;
                    operand_b <= w.operand_b;
                    operand_c <= w.operand_c;
                    // Pick the idle stretch that follows this word: mostly no gap,
                    // sometimes a short gap, now and then a long one.
                    case ($urandom_range(0, 19)) inside
                        0:       gap_left <= $urandom_range(20, 90);
                        1, 2, 3: gap_left <= $urandom_range(1, 4);
                        default: gap_left <= 0;
                    endcase
                end
                start <= offer;
            end
        end
    end

    // Monitor: every done cycle carries one result word; drop the oldest
    // expectation and compare each field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_count  <= 0;
            results_seen <= 0;
        end
        else if (done)
        begin
            alu_result_t exp_res;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h dz=%b", $time,
                         result_value, divide_by_zero);
                error_count <= error_count + 1;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result_value !== exp_res.value || divide_by_zero !== exp_res.dz)
                begin
                    $display("%0t: mismatch expected value=%h dz=%b actual value=%h dz=%b",
                             $time, exp_res.value, exp_res.dz, result_value,
                             divide_by_zero);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no word or result accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !start);
        wait (expected_results.size() == 0);
        // Hold a little past the pipeline depth for any stray result.
        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d operation words and %0d results, all opcodes 0..31,",
                 words_sent, results_seen);
        $display("zero divisors, MIN / -1 wrap and shift amount masking.");
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
